FILE: rtl/core/ordered_list_deque_with_search_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list deque unit
// Concurrent checks on the unit clock and reset; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH
`define ORDERED_LIST_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define OLDS_ASSERT_IMPL(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);
// Next-cycle implication.
`define OLDS_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);
`else
`define OLDS_ASSERT_IMPL(label, cond, expr, msg)
`define OLDS_ASSERT_NEXT(label, cond, expr, msg)
`endif
`endif

FILE: rtl/core/olds_pkg.sv
// ----------------------------------------------------------------------------
// olds_pkg
// Shared constants, request and status codes, and cell control types.
// ----------------------------------------------------------------------------
package olds_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT,
    REQ_PUSH_BACK,
    REQ_POP_FRONT,
    REQ_POP_BACK,
    REQ_DELETE,
    REQ_SEARCH,
    REQ_MINMAX
  } req_t;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_LEFT,
    CMD_RIGHT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      compare;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/olds_cell.sv
// ----------------------------------------------------------------------------
// olds_cell
// One storage cell of the list: holds a value, shifts to or from its
// neighbors, and flags a match for the first-match chain.
// ----------------------------------------------------------------------------
module olds_cell import olds_pkg::*; (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic                    valid,
  input  logic signed [VAL_W-1:0] left_data,
  input  logic signed [VAL_W-1:0] right_data,
  input  logic signed [VAL_W-1:0] load_data,
  input  logic signed [VAL_W-1:0] cmp_data,
  input  logic                    hit_in,
  output logic signed [VAL_W-1:0] data,
  output logic                    hit_out
);

  logic eq;

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CMD_HOLD:  data <= data;
      CMD_LOAD:  data <= load_data;
      CMD_LEFT:  data <= left_data;
      CMD_RIGHT: data <= right_data;
      default:   data <= data;
    endcase
    if (ctrl.compare) begin
      eq <= valid && (data == cmp_data);
    end
  end

  // A cell is at or past the first match when it or any cell in front matches.
  assign hit_out = hit_in | eq;

endmodule

FILE: rtl/core/olds_minmax.sv
// ----------------------------------------------------------------------------
// olds_minmax
// Walks the valid cells one per cycle and keeps the running max and min.
// ----------------------------------------------------------------------------
module olds_minmax import olds_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    launch,
  input  logic [CNT_W-1:0]        n,
  input  logic signed [VAL_W-1:0] rd_data,
  output logic [IDX_W-1:0]        rd_idx,
  output logic                    done,
  output logic signed [VAL_W-1:0] max_value,
  output logic signed [VAL_W-1:0] min_value
);

  logic running;
  logic first;
  logic last;

  assign last = (CNT_W'(rd_idx) + CNT_W'(1)) == n;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      rd_idx  <= '0;
      first   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (launch) begin
        running <= 1'b1;
        rd_idx  <= '0;
        first   <= 1'b1;
      end else if (running) begin
        if (first || rd_data > max_value) begin
          max_value <= rd_data;
        end
        if (first || rd_data < min_value) begin
          min_value <= rd_data;
        end
        first <= 1'b0;
        if (last) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          rd_idx <= rd_idx + IDX_W'(1);
        end
      end
    end
  end

endmodule

FILE: rtl/core/ordered_list_deque_with_search_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_deque_with_search_unit
// Bounded deque of signed values kept as a chain of cells, front at cell 0,
// with push/pop at both ends, delete of the first match, search and min/max.
// ----------------------------------------------------------------------------
//
//  Channel   | Handshake            | Payload
//  ----------+----------------------+-------------------------------------------
//  request   | start, busy          | req_type, value
//  result    | done (one-cycle)     | value_out, found, max_value, min_value,
//            |                      | status, count
//
// A transaction is accepted on a rising edge with start high and busy low.
// Push, pop, delete, search and unused codes pass through the apply state: the
// accept edge registers every cell's compare against the value, and the edge
// that ends the apply state shifts the cells and registers the result. Min/max
// on a non-empty list then passes through the scan state, where the scan unit
// reads one cell per cycle through the shared read port. Busy falls in the
// done cycle, so the next request may be accepted while the result is shown.
// Reset clears the entry count and the control state and holds busy high;
// cell contents are not cleared. The receiver cannot stall: each result is
// valid for exactly its done cycle.
// ----------------------------------------------------------------------------
`include "ordered_list_deque_with_search_unit_assert.svh"

module ordered_list_deque_with_search_unit import olds_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [REQ_W-1:0]           req_type,
  input  logic signed [VAL_W-1:0]    value,
  output logic                       done,
  output logic signed [VAL_W-1:0]    value_out,
  output logic                       found,
  output logic signed [VAL_W-1:0]    max_value,
  output logic signed [VAL_W-1:0]    min_value,
  output logic [STATUS_W-1:0]        status,
  output logic [CNT_W-1:0]           count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_SCAN
  } state_t;

  state_t                  state;
  req_t                    req_q;
  logic signed [VAL_W-1:0] val_q;

  logic                    accept;
  logic                    full;
  logic                    empty;
  logic                    hit_end;

  // Per-cell wiring of the chain.
  cell_ctrl_t              ctrl     [CAPACITY];
  logic signed [VAL_W-1:0] cell_data[CAPACITY];
  logic                    hit_out  [CAPACITY];

  // Shared read port: the scan index during a scan, the last entry (for pop back) otherwise.
  logic [IDX_W-1:0]        last_idx;
  logic [IDX_W-1:0]        rd_idx;
  logic signed [VAL_W-1:0] rd_data;

  // Min/max scan unit.
  logic                    mm_launch;
  logic [IDX_W-1:0]        mm_idx;
  logic                    mm_done;
  logic signed [VAL_W-1:0] mm_max;
  logic signed [VAL_W-1:0] mm_min;

  // Busy is also held during reset so that nothing is taken while it is applied.
  assign busy     = rst || (state != S_IDLE);
  assign accept   = start && !busy;
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign hit_end  = hit_out[CAPACITY-1];
  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign rd_idx   = (state == S_SCAN) ? mm_idx : last_idx;
  assign rd_data  = cell_data[rd_idx];

  assign mm_launch = (state == S_APPLY) && (req_q == REQ_MINMAX) && !empty;

  // The chain of cells. Each cell sees its two neighbors; cell 0 takes the
  // request value from the left on a front push, and the last cell simply
  // reloads itself on a shift toward the front since it falls out of range.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_d;
    logic signed [VAL_W-1:0] right_d;
    logic                    hit_in;
    logic                    valid;

    if (i == 0) begin : g_front
      assign left_d = val_q;
      assign hit_in = 1'b0;
    end else begin : g_inner
      assign left_d = cell_data[i-1];
      assign hit_in = hit_out[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign right_d = cell_data[i];
    end else begin : g_body
      assign right_d = cell_data[i+1];
    end

    assign valid = CNT_W'(i) < count;

    // Compare is taken on the accept edge against the incoming value, so the
    // first-match chain is settled from registers during the apply cycle.
    always_comb begin
      ctrl[i].cmd     = CMD_HOLD;
      ctrl[i].compare = accept;
      if (state == S_APPLY) begin
        case (req_q)
          REQ_PUSH_FRONT: begin
            if (!full) begin
              ctrl[i].cmd = CMD_LEFT;
            end
          end
          REQ_PUSH_BACK: begin
            if (!full && count == CNT_W'(i)) begin
              ctrl[i].cmd = CMD_LOAD;
            end
          end
          REQ_POP_FRONT: begin
            if (!empty) begin
              ctrl[i].cmd = CMD_RIGHT;
            end
          end
          REQ_DELETE: begin
            // Every cell from the first match on closes the gap.
            if (hit_out[i]) begin
              ctrl[i].cmd = CMD_RIGHT;
            end
          end
          default: begin
            ctrl[i].cmd = CMD_HOLD;
          end
        endcase
      end
    end

    olds_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .valid      (valid),
      .left_data  (left_d),
      .right_data (right_d),
      .load_data  (val_q),
      .cmp_data   (value),
      .hit_in     (hit_in),
      .data       (cell_data[i]),
      .hit_out    (hit_out[i])
    );
  end

  olds_minmax u_minmax (
    .clk       (clk),
    .rst       (rst),
    .launch    (mm_launch),
    .n         (count),
    .rd_data   (rd_data),
    .rd_idx    (mm_idx),
    .done      (mm_done),
    .max_value (mm_max),
    .min_value (mm_min)
  );

  // Sequencer: holds the request, the entry count and the result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req_q <= req_t'(req_type);
            val_q <= value;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          state     <= S_IDLE;
          done      <= 1'b1;
          value_out <= '0;
          found     <= 1'b0;
          max_value <= '0;
          min_value <= '0;
          status    <= ST_OK;
          case (req_q)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              if (full) begin
                status <= ST_FULL;
              end else begin
                count <= count + CNT_W'(1);
              end
            end
            REQ_POP_FRONT: begin
              if (empty) begin
                status <= ST_EMPTY;
              end else begin
                value_out <= cell_data[0];
                count     <= count - CNT_W'(1);
              end
            end
            REQ_POP_BACK: begin
              if (empty) begin
                status <= ST_EMPTY;
              end else begin
                value_out <= rd_data;
                count     <= count - CNT_W'(1);
              end
            end
            REQ_DELETE: begin
              value_out <= val_q;
              found     <= hit_end;
              if (hit_end) begin
                count <= count - CNT_W'(1);
              end
            end
            REQ_SEARCH: begin
              value_out <= val_q;
              found     <= hit_end;
            end
            REQ_MINMAX: begin
              if (empty) begin
                status <= ST_EMPTY;
              end else begin
                // The result waits for the scan; other fields stay cleared.
                done  <= 1'b0;
                state <= S_SCAN;
              end
            end
            default: begin
              status <= ST_OK;
            end
          endcase
        end
        S_SCAN: begin
          if (mm_done) begin
            done      <= 1'b1;
            max_value <= mm_max;
            min_value <= mm_min;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A dropped push can only happen with every cell in use.
  `OLDS_ASSERT_IMPL(a_full_count, done && status == ST_FULL, full, "full status with free cells")
  // A hit never comes with an error status.
  `OLDS_ASSERT_IMPL(a_found_ok, done && found, status == ST_OK, "found with error status")
  // An accepted transaction always occupies the unit for the next cycle.
  `OLDS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction not held")
  // The entry count never runs past the capacity.
  `OLDS_ASSERT_IMPL(a_count_range, done, count <= CNT_W'(CAPACITY), "entry count out of range")

endmodule

FILE: sim/deque_check_pkg.sv
// ----------------------------------------------------------------------------
// Deque response tracker
// Keeps its own copy of the list contents, works out the response that each
// accepted request must produce, and checks the responses in order.
// ----------------------------------------------------------------------------
package deque_check_pkg;
  import olds_pkg::*;

  // Selector code with no request behind it; the unit must leave the list alone.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

  typedef struct {
    logic signed [VAL_W-1:0] value_out;
    logic                    found;
    logic signed [VAL_W-1:0] max_value;
    logic signed [VAL_W-1:0] min_value;
    logic [STATUS_W-1:0]     status;
    logic [CNT_W-1:0]        count;
  } deque_response_t;

  class deque_tracker;
    logic signed [VAL_W-1:0] entries [CAPACITY];
    int unsigned             depth;
    deque_response_t         pending[$];
    int unsigned             errors;

    function new();
      depth  = 0;
      errors = 0;
    endfunction

    // Applies one accepted request to the list copy and queues its response.
    function void note_request(logic [REQ_W-1:0] code, logic signed [VAL_W-1:0] operand);
      deque_response_t rsp;
      int              i;
      int              hit;
      rsp = '{default: '0};
      hit = -1;
      if (code == REQ_DELETE || code == REQ_SEARCH) begin
        rsp.value_out = operand;
        for (i = 0; i < depth; i++) begin
          if (entries[i] == operand) begin
            hit = i;
            break;
          end
        end
        rsp.found = (hit >= 0);
      end
      case (code)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (depth >= CAPACITY) begin
            rsp.status = ST_FULL;
          end else begin
            if (code == REQ_PUSH_FRONT) begin
              for (i = depth; i > 0; i--) entries[i] = entries[i-1];
              entries[0] = operand;
            end else begin
              entries[depth] = operand;
            end
            depth++;
          end
        end
        REQ_POP_FRONT: begin
          if (depth == 0) begin
            rsp.status = ST_EMPTY;
          end else begin
            rsp.value_out = entries[0];
            for (i = 0; i + 1 < depth; i++) entries[i] = entries[i+1];
            depth--;
          end
        end
        REQ_POP_BACK: begin
          if (depth == 0) begin
            rsp.status = ST_EMPTY;
          end else begin
            depth--;
            rsp.value_out = entries[depth];
          end
        end
        REQ_DELETE: begin
          if (hit >= 0) begin
            for (i = hit; i + 1 < depth; i++) entries[i] = entries[i+1];
            depth--;
          end
        end
        REQ_MINMAX: begin
          if (depth == 0) begin
            rsp.status = ST_EMPTY;
          end else begin
            rsp.max_value = entries[0];
            rsp.min_value = entries[0];
            for (i = 1; i < depth; i++) begin
              if (entries[i] > rsp.max_value) rsp.max_value = entries[i];
              if (entries[i] < rsp.min_value) rsp.min_value = entries[i];
            end
          end
        end
        default: begin
        end
      endcase
      rsp.count = CNT_W'(depth);
      pending.push_back(rsp);
    endfunction

    // Compares one response from the unit with the oldest one still owed.
    function void check_result(deque_response_t got);
      deque_response_t want;
      if (pending.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.value_out !== want.value_out) begin
        $error("value_out: expected %0d, got %0d", want.value_out, got.value_out);
        errors++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        errors++;
      end
      if (got.max_value !== want.max_value) begin
        $error("max_value: expected %0d, got %0d", want.max_value, got.max_value);
        errors++;
      end
      if (got.min_value !== want.min_value) begin
        $error("min_value: expected %0d, got %0d", want.min_value, got.min_value);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

endpackage

FILE: sim/tb_ordered_list_deque_with_search_unit.sv
// ----------------------------------------------------------------------------
// Testbench for ordered_list_deque_with_search_unit
// Drives requests through the start/busy handshake, predicts every response
// with a software copy of the list, and checks each done-strobed response in
// order. A directed pass covers the empty and corner cases; random phases then
// push the list to full, drain it to empty and mix all requests in between.
// ----------------------------------------------------------------------------
module tb_ordered_list_deque_with_search_unit import olds_pkg::*, deque_check_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted request or response before the run is declared hung.
  // Even the slowest transaction (min/max on a full list) plus the sender's longest
  // idle gap stays far below this limit, so it is far above a legal gap.
  localparam int STALL_LIMIT   = 4000;
  // Quiet time after the last response, enough for a stray min/max to show up.
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
  localparam int RANDOM_ITEMS  = 630;
  localparam int POOL_SIZE     = 6;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [REQ_W-1:0]        req_type = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic                    busy;
  logic                    done;
  logic signed [VAL_W-1:0] value_out;
  logic                    found;
  logic signed [VAL_W-1:0] max_value;
  logic signed [VAL_W-1:0] min_value;
  logic [STATUS_W-1:0]     status;
  logic [CNT_W-1:0]        count;

  deque_tracker            tracker = new();
  int unsigned             stall_cycles = 0;
  // Values reused within a phase so that searches and deletes find matches.
  logic signed [VAL_W-1:0] value_pool [POOL_SIZE];
  // When set, the sender issues back to back with no idle cycles.
  bit                      burst = 1'b0;

  ordered_list_deque_with_search_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .value     (value),
    .done      (done),
    .value_out (value_out),
    .found     (found),
    .max_value (max_value),
    .min_value (min_value),
    .status    (status),
    .count     (count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Response monitor. Outputs are sampled at the edge that ends the done
  // cycle; the unit updates them with nonblocking assignments, so the values
  // read here are the ones that were on the ports during that cycle.
  always @(posedge clk) begin
    deque_response_t got;
    if (!rst && done) begin
      got.value_out = value_out;
      got.found     = found;
      got.max_value = max_value;
      got.min_value = min_value;
      got.status    = status;
      got.count     = count;
      tracker.check_result(got);
    end
  end

  // Watchdog: any accepted request or response restarts the count.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Issues one request. A gap of zero keeps start high from the previous
  // transaction, so start is never dropped and raised within one time step.
  // Busy is read right after the edge, which still gives its pre-edge value.
  task automatic send_request(input logic [REQ_W-1:0] code,
                              input logic signed [VAL_W-1:0] operand);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    req_type <= code;
    value    <= operand;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_request(code, operand);
  endtask

  // Holds the sender off until every outstanding response has come back.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] corner_value();
    case ($urandom_range(0, 4))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  // Pool values in 45 of 100 draws so that duplicates and hits are common, with corners
  // and fully random words mixed in to exercise every bit of the operand.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 60) return corner_value();
    return $urandom;
  endfunction

  // The push and pop shares steer the list depth: fill phases reach the full
  // limit and keep pushing into it, drain phases pop past empty.
  function automatic logic [REQ_W-1:0] pick_code(traffic_mode_t mode);
    int unsigned roll;
    int unsigned push_pct;
    int unsigned pop_pct;
    roll     = $urandom_range(0, 99);
    push_pct = (mode == MODE_FILL) ? 55 : (mode == MODE_DRAIN) ? 10 : 30;
    pop_pct  = (mode == MODE_DRAIN) ? 55 : (mode == MODE_FILL) ? 10 : 30;
    if (roll < push_pct) return $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    roll -= push_pct;
    if (roll < pop_pct) return $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
    roll -= pop_pct;
    if (roll < 12) return REQ_DELETE;
    if (roll < 24) return REQ_SEARCH;
    if (roll < 33) return REQ_MINMAX;
    return REQ_UNUSED;
  endfunction

  initial begin
    int unsigned   sent;
    int unsigned   phase_len;
    int            k;
    traffic_mode_t mode;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass. Every request on the empty list first: pops and min/max
    // report empty, delete and search miss with the operand echoed, and the
    // unused selector changes nothing.
    send_request(REQ_POP_FRONT, 32'sd0);
    send_request(REQ_POP_BACK, 32'sd0);
    send_request(REQ_MINMAX, 32'sd0);
    send_request(REQ_DELETE, 32'sh8000_0000);
    send_request(REQ_SEARCH, 32'sh7FFF_FFFF);
    send_request(REQ_UNUSED, -32'sd1);
    // Extremes at both ends, then a duplicate so that delete must take only
    // the first match: the list becomes -1, MIN, MAX, 0, -1.
    send_request(REQ_PUSH_BACK, 32'sh7FFF_FFFF);
    send_request(REQ_PUSH_FRONT, 32'sh8000_0000);
    send_request(REQ_PUSH_BACK, 32'sd0);
    send_request(REQ_PUSH_FRONT, -32'sd1);
    send_request(REQ_PUSH_BACK, -32'sd1);
    send_request(REQ_MINMAX, 32'sd0);
    send_request(REQ_SEARCH, 32'sd0);
    send_request(REQ_SEARCH, 32'sd5);
    send_request(REQ_DELETE, -32'sd1);
    send_request(REQ_DELETE, 32'sd12345);
    send_request(REQ_MINMAX, 32'sd0);
    send_request(REQ_POP_FRONT, 32'sd0);
    send_request(REQ_POP_BACK, 32'sd0);
    send_request(REQ_UNUSED, 32'sh7FFF_FFFF);
    // Let the directed traffic finish completely before random phases start.
    wait_drained();

    // Random phases, each with its own value pool, traffic mode and idling.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      for (k = 0; k < POOL_SIZE; k++) begin
        value_pool[k] = ($urandom_range(0, 3) == 0) ? corner_value() : $urandom;
      end
      case ($urandom_range(0, 2))
        0:       mode = MODE_FILL;
        1:       mode = MODE_DRAIN;
        default: mode = MODE_MIXED;
      endcase
      burst     = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 70);
      for (k = 0; k < phase_len; k++) begin
        send_request(pick_code(mode), pick_value());
      end
      sent += phase_len;
      if ($urandom_range(0, 1)) wait_drained();
    end
    burst = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.pending.size() != 0) begin
      $error("%0d responses never arrived", tracker.pending.size());
    end
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/olds_pkg.sv
rtl/core/olds_cell.sv
rtl/core/olds_minmax.sv
rtl/core/ordered_list_deque_with_search_unit.sv
sim/deque_check_pkg.sv
sim/tb_ordered_list_deque_with_search_unit.sv
